// File: sv/plc_pkg.sv
`default_nettype none

package plc_pkg;

   localparam int CAPACITY = 64;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int VAL_W    = 32;
   localparam int POS_W    = 7;
   localparam int LEN_W    = 7;
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_INSERT     = 3'd2;
   localparam logic [2:0] OP_DELETE     = 3'd3;
   localparam logic [2:0] OP_POP_FRONT  = 3'd4;
   localparam logic [2:0] OP_POP_BACK   = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_POS   = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef enum logic [1:0] {
      SH_HOLD = 2'd0,
      SH_INS  = 2'd1,
      SH_DEL  = 2'd2
   } shift_type;

   typedef struct packed {
      logic [2:0]              opcode;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [LEN_W-1:0]        length;
      logic signed [VAL_W-1:0] removed_value;
   } rsp_type;

   typedef struct packed {
      shift_type         kind;
      logic [IDX_W-1:0]  idx;
      logic [VAL_W-1:0]  value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: sv/plc_cell.sv
`default_nettype none

module plc_cell (
   input  wire                          clock,
   input  wire [plc_pkg::IDX_W-1:0]     cell_index,
   input  wire plc_pkg::cell_ctrl_type  ctrl,
   input  wire [plc_pkg::VAL_W-1:0]     left_value,
   input  wire [plc_pkg::VAL_W-1:0]     right_value,
   output logic [plc_pkg::VAL_W-1:0]    value,
   output logic [plc_pkg::VAL_W-1:0]    pick_value
);
   import plc_pkg::*;

   logic [VAL_W-1:0] value_ff;
   logic [VAL_W-1:0] value_in;
   logic             is_at;
   logic             is_after;

   assign is_at    = (cell_index == ctrl.idx);
   assign is_after = (cell_index > ctrl.idx);

   always_comb begin
      value_in = value_ff;
      case (ctrl.kind)
         SH_INS: begin
            if (is_at) begin
               value_in = ctrl.value;
            end else if (is_after) begin
               value_in = left_value;
            end
         end
         SH_DEL: begin
            if (is_at || is_after) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign pick_value = is_at ? value_ff : '0;

endmodule

`default_nettype wire

// File: sv/plc_ctrl.sv
`default_nettype none

module plc_ctrl (
   input  wire plc_pkg::req_type         req,
   input  wire                           fire,
   input  wire [plc_pkg::CNT_W-1:0]      count,
   output plc_pkg::cell_ctrl_type        ctrl,
   output logic [1:0]                    status,
   output logic [plc_pkg::CNT_W-1:0]     count_next
);
   import plc_pkg::*;

   logic             full;
   logic             empty;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [IDX_W-1:0] pos_idx;
   logic [IDX_W-1:0] last_idx;
   shift_type        kind;

   assign full     = (count >= CNT_W'(CAPACITY));
   assign empty    = (count == '0);
   assign pos_ext  = CMP_W'(req.position);
   assign cnt_ext  = CMP_W'(count);
   assign pos_idx  = IDX_W'(req.position - POS_W'(1));
   // tail slot on push back
   assign last_idx = IDX_W'(count);

   always_comb begin
      status     = ST_OK;
      kind       = SH_HOLD;
      ctrl.idx   = '0;
      ctrl.value = req.value;
      case (req.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               kind     = SH_INS;
               ctrl.idx = (req.opcode == OP_PUSH_FRONT) ? '0 : last_idx;
            end
         end
         OP_INSERT: begin
            if (req.position == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
               status = ST_POS;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               kind     = SH_INS;
               ctrl.idx = pos_idx;
            end
         end
         OP_DELETE: begin
            if (req.position == '0 || pos_ext > cnt_ext) begin
               status = ST_POS;
            end else begin
               kind     = SH_DEL;
               ctrl.idx = pos_idx;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               kind     = SH_DEL;
               ctrl.idx = (req.opcode == OP_POP_FRONT) ? '0
                                                        : IDX_W'(count - CNT_W'(1));
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      ctrl.kind = fire ? kind : SH_HOLD;
   end

   always_comb begin
      case (ctrl.kind)
         SH_INS:  count_next = count + CNT_W'(1);
         SH_DEL:  count_next = count - CNT_W'(1);
         default: count_next = count;
      endcase
   end

endmodule

`default_nettype wire

// File: sv/positional_ordered_list.sv
// rsp_valid strobes in the cycle after the start transfer
// throughput: one request per cycle, busy stays low; every cell shifts or holds
// in parallel in the same cycle the request is taken
// the receiver cannot stall; rsp_data keeps each result until the next start
// synchronous active-high reset empties the list; stored values need no clearing
`default_nettype none

module positional_ordered_list (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire plc_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output plc_pkg::rsp_type       rsp_data
);
   import plc_pkg::*;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              fire;
   cell_ctrl_type     ctrl;
   logic [1:0]        status;
   logic [VAL_W-1:0]  cell_value [CAPACITY];
   logic [VAL_W-1:0]  pick_value [CAPACITY];
   logic [VAL_W-1:0]  picked;

   assign busy = 1'b0;
   assign fire = start && !busy;

   plc_ctrl u_ctrl (
      .req        (req_data),
      .fire       (fire),
      .count      (count_ff),
      .ctrl       (ctrl),
      .status     (status),
      .count_next (count_in)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VAL_W-1:0] left_value;
      logic [VAL_W-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_l
         assign left_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_mid_r
         assign right_value = cell_value[i+1];
      end
      plc_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(i)),
         .ctrl        (ctrl),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .pick_value  (pick_value[i])
      );
   end

   // only the addressed cell drives a nonzero pick value
   always_comb begin
      picked = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         picked = picked | pick_value[k];
      end
   end

   always_comb begin
      rsp_in.status        = status;
      rsp_in.length        = LEN_W'(count_in);
      rsp_in.removed_value = (ctrl.kind == SH_DEL) ? picked : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
